>>> hdl/nscp_pkg.sv
// Package for the NMEA sentence checksum parser: character codes, controller
// state type, command/status structs and the hex checksum decode.
// No dependencies.
`timescale 1ns / 1ps

package nscp_pkg;

  localparam int unsigned MAX_SENTENCE_LEN = 64;
  localparam int unsigned MSG_LEN_W        = 6;
  localparam int unsigned BYTE_W           = 8;

  localparam logic [7:0] CH_START = 8'h24;  // '$'
  localparam logic [7:0] CH_MARK  = 8'h2A;  // '*'
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_FETCH,
    ST_DRAIN
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic take;     // input transaction this cycle
    logic fetch;    // read first body byte
    logic advance;  // output transaction on a byte that is not the last
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;     // current input byte completes a sentence
    logic last;     // byte on the output is the final body byte
  } status_t;

  // Returns {valid, digit}.
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [7:0] t;
    logic [4:0] v;
    begin
      v = 5'b0;
      t = 8'h00;
      if (ch >= 8'h30 && ch <= 8'h39) begin
        v = {1'b1, ch[3:0]};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
        t = ch - 8'h37;
        v = {1'b1, t[3:0]};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
        t = ch - 8'h57;
        v = {1'b1, t[3:0]};
      end
      return v;
    end
  endfunction

  // A non-hex character ends the number.
  function automatic logic [7:0] parse_two_hex(input logic [7:0] first,
                                               input logic [7:0] second);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] r;
    begin
      hi = hex_value(first);
      lo = hex_value(second);
      if (!hi[4]) begin
        r = 8'h00;
      end else if (!lo[4]) begin
        r = {4'h0, hi[3:0]};
      end else begin
        r = {hi[3:0], lo[3:0]};
      end
      return r;
    end
  endfunction

endpackage

>>> hdl/nscp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nscp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/nscp_ctrl.sv
// Controller for the NMEA sentence checksum parser: receive / fetch / drain
// sequencing and the channel handshakes. Depends on nscp_pkg.
`timescale 1ns / 1ps

module nscp_ctrl import nscp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECV;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RECV: begin
        if (in_valid_i && status_i.done) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (out_ready_i && status_i.last) begin
          state_d = ST_RECV;
        end
      end
      default: begin
        state_d = ST_RECV;
      end
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    cmd_o        = '0;
    unique case (state_q)
      ST_RECV: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      ST_DRAIN: begin
        out_valid_o   = 1'b1;
        cmd_o.advance = out_ready_i && !status_i.last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

>>> hdl/nscp_dpath.sv
// Datapath for the NMEA sentence checksum parser: character decode, running
// XOR, positions, checksum capture and body store. Depends on nscp_pkg, nscp_ram.
`timescale 1ns / 1ps

module nscp_dpath import nscp_pkg::*; #(
  parameter int unsigned MaxLen = MAX_SENTENCE_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic [BYTE_W-1:0]    msg_byte_o,
  output logic [MSG_LEN_W-1:0] msg_length_o,
  output logic                 checksum_ok_o,
  output logic                 last_o
);

  localparam int unsigned AddrW = $clog2(MaxLen);
  localparam int unsigned PosW  = $clog2(MaxLen + 1);
  localparam int unsigned CmpW  = PosW + 1;
  localparam int unsigned ExtW  = (AddrW > MSG_LEN_W) ? AddrW : MSG_LEN_W;

  logic [BYTE_W-1:0] xor_q, xor_d;
  logic              recv_q, recv_d;
  logic [PosW-1:0]   wp_q, wp_d;
  logic              mark_seen_q, mark_seen_d;
  logic [AddrW-1:0]  mark_q, mark_d;
  logic [BYTE_W-1:0] hex_hi_q, hex_hi_d;
  logic              ok_q, ok_d;
  logic [AddrW-1:0]  cnt_q, cnt_d;

  logic             is_start, is_mark, is_eol;
  logic             room, store, done;
  logic [CmpW-1:0]  wp_x, wp_next_x, mark2_x;
  logic [AddrW:0]   cnt_inc_x;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [ExtW-1:0]  mark_ext;

  assign is_start = (rx_byte_i == CH_START);
  assign is_mark  = (rx_byte_i == CH_MARK);
  assign is_eol   = (rx_byte_i == CH_CR) || (rx_byte_i == CH_LF);

  assign wp_x    = CmpW'(wp_q);
  assign mark2_x = CmpW'(mark_q) + CmpW'(2);
  assign room    = recv_q && (wp_q < PosW'(MaxLen));
  assign store   = cmd_i.take && !is_start && !is_mark && !is_eol && room &&
                   (!mark_seen_q || (wp_x < mark2_x));
  assign wp_next_x = store ? (wp_x + CmpW'(1)) : wp_x;
  assign done    = cmd_i.take && !is_start && !is_mark && !is_eol && recv_q &&
                   mark_seen_q && (mark_q != '0) && (wp_next_x == mark2_x);

  always_comb begin
    xor_d       = xor_q;
    recv_d      = recv_q;
    wp_d        = wp_q;
    mark_seen_d = mark_seen_q;
    mark_d      = mark_q;
    hex_hi_d    = hex_hi_q;
    ok_d        = ok_q;
    if (cmd_i.take) begin
      if (is_start) begin
        xor_d       = '0;
        recv_d      = 1'b1;
        wp_d        = '0;
        mark_seen_d = 1'b0;
        mark_d      = '0;
      end else if (is_mark) begin
        if (room) begin
          mark_seen_d = 1'b1;
          mark_d      = wp_q[AddrW-1:0];
        end
      end else if (!is_eol) begin
        if (store) begin
          wp_d = wp_q + PosW'(1);
          // capture the first checksum digit as it goes by
          if (mark_seen_q && (wp_x == CmpW'(mark_q))) begin
            hex_hi_d = rx_byte_i;
          end
        end
        if (room && !mark_seen_q) begin
          xor_d = xor_q ^ rx_byte_i;
        end
        if (done) begin
          recv_d = 1'b0;
          ok_d   = (xor_q == parse_two_hex(hex_hi_q, rx_byte_i));
        end
      end
    end
  end

  assign cnt_inc_x = {1'b0, cnt_q} + {{AddrW{1'b0}}, 1'b1};

  always_comb begin
    cnt_d = cnt_q;
    if (done) begin
      cnt_d = '0;
    end else if (cmd_i.advance) begin
      cnt_d = cnt_inc_x[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_q       <= '0;
      recv_q      <= 1'b0;
      wp_q        <= '0;
      mark_seen_q <= 1'b0;
      mark_q      <= '0;
      cnt_q       <= '0;
    end else begin
      xor_q       <= xor_d;
      recv_q      <= recv_d;
      wp_q        <= wp_d;
      mark_seen_q <= mark_seen_d;
      mark_q      <= mark_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hex_hi_q <= hex_hi_d;
    ok_q     <= ok_d;
  end

  // Read the first body byte on fetch, and prefetch the next one on each output transaction that is not the last.
  assign re    = cmd_i.fetch || cmd_i.advance;
  assign raddr = cmd_i.fetch ? cnt_q : cnt_inc_x[AddrW-1:0];

  nscp_ram #(
    .Width (BYTE_W),
    .Depth (MaxLen)
  ) u_body_ram (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (wp_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (msg_byte_o)
  );

  assign mark_ext      = ExtW'(mark_q);
  assign msg_length_o  = mark_ext[MSG_LEN_W-1:0];
  assign checksum_ok_o = ok_q;
  assign last_o        = (cnt_inc_x == {1'b0, mark_q});

  assign status_o.done = done;
  assign status_o.last = last_o;

endmodule

>>> hdl/nmea_sentence_checksum_parser_unit.sv
// Top level of the NMEA sentence checksum parser: controller plus datapath.
// Depends on nscp_pkg, nscp_ctrl, nscp_dpath.
`timescale 1ns / 1ps

// Takes one received byte per cycle while in_ready_o is high. '$' starts a
// sentence, CR and LF are ignored, body bytes are stored and XORed until '*',
// and the two characters after the mark are read as the hex checksum. The byte
// that completes a sentence ends reception: in_ready_o drops, the fetch state
// makes the first read of the body buffer, and the N body bytes leave one
// per cycle while out_ready_i is high, so a completed sentence holds off the
// input until its last body byte has left. The body buffer's single read port
// sets that drain rate. No clearing pass is needed after reset.

module nmea_sentence_checksum_parser_unit import nscp_pkg::*; #(
  parameter int unsigned MaxSentenceLen = MAX_SENTENCE_LEN
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BYTE_W-1:0]    msg_byte_o,
  output logic [MSG_LEN_W-1:0] msg_length_o,
  output logic                 checksum_ok_o,
  output logic                 last_o
);

  cmd_t    cmd;
  status_t status;

  nscp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nscp_dpath #(
    .MaxLen (MaxSentenceLen)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .rx_byte_i     (rx_byte_i),
    .msg_byte_o    (msg_byte_o),
    .msg_length_o  (msg_length_o),
    .checksum_ok_o (checksum_ok_o),
    .last_o        (last_o)
  );

endmodule

>>> hdl/nscp_checker.sv
// Port-level checker for the NMEA sentence checksum parser, bound to the top
// level. Depends on nscp_pkg and nmea_sentence_checksum_parser_unit.
`timescale 1ns / 1ps

module nscp_checker import nscp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [BYTE_W-1:0]    msg_byte_o,
  input logic [MSG_LEN_W-1:0] msg_length_o,
  input logic                 checksum_ok_o,
  input logic                 last_o
);

  // Input is held off for the whole drain.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a sentence is draining");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(msg_byte_o) &&
    $stable(last_o))
    else $error("stalled output transaction changed");

  // A drain runs without gaps and keeps its sentence fields.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
    out_valid_o && $stable(msg_length_o) && $stable(checksum_ok_o))
    else $error("gap or field change inside a sentence drain");

  a_back_to_recv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o && !out_valid_o)
    else $error("receiver not back after the last body byte");

endmodule

bind nmea_sentence_checksum_parser_unit nscp_checker u_nscp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .msg_byte_o    (msg_byte_o),
  .msg_length_o  (msg_length_o),
  .checksum_ok_o (checksum_ok_o),
  .last_o        (last_o)
);

>>> test/nscp_sentence_checker.sv
// Checker for the NMEA sentence checksum parser: watches the byte and result
// channels, predicts each emitted sentence body and compares it field by field.
// Depends on nscp_pkg.
`timescale 1ns / 1ps

module nscp_sentence_checker import nscp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [BYTE_W-1:0]    msg_byte_i,
  input  logic [MSG_LEN_W-1:0] msg_length_i,
  input  logic                 checksum_ok_i,
  input  logic                 last_i,
  output int unsigned          pending_o,
  output int unsigned          fail_count_o
);

  localparam int HEX_BASE = 16;

  typedef struct packed {
    logic [BYTE_W-1:0]    data;
    logic [MSG_LEN_W-1:0] len;
    logic                 ok;
    logic                 fin;
  } body_beat_t;

  body_beat_t        body_beat_q[$];
  body_beat_t        head;
  logic [BYTE_W-1:0] body_mem [MAX_SENTENCE_LEN];
  logic [BYTE_W-1:0] parity;
  logic              in_sentence;
  logic              marked;
  int unsigned       wr_pos;
  int unsigned       mark_pos;

  function automatic int digit_of(input logic [7:0] ch);
    if (ch >= "0" && ch <= "9") return int'(ch - "0");
    if (ch >= "A" && ch <= "F") return ch - "A" + 10;
    if (ch >= "a" && ch <= "f") return ch - "a" + 10;
    return -1;
  endfunction

  // A non-hex character ends the number.
  function automatic logic [7:0] checksum_of(input logic [7:0] hi_ch, input logic [7:0] lo_ch);
    int hi;
    int lo;
    hi = digit_of(hi_ch);
    lo = digit_of(lo_ch);
    if (hi < 0) return 8'h00;
    if (lo < 0) return 8'(hi);
    return 8'(hi * HEX_BASE + lo);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    fail_count_o++;
  endtask

  // Update the sentence state with one accepted byte and queue any body it completes.
  task automatic absorb_char(input logic [7:0] ch);
    body_beat_t        beat;
    logic [BYTE_W-1:0] sum;
    logic              match;
    if (ch == CH_START) begin
      parity      = '0;
      in_sentence = 1'b1;
      wr_pos      = 0;
      marked      = 1'b0;
      mark_pos    = 0;
    end else if (ch == CH_MARK) begin
      if (in_sentence && wr_pos < MAX_SENTENCE_LEN) begin
        marked   = 1'b1;
        mark_pos = wr_pos;
      end
    end else if (ch != CH_CR && ch != CH_LF) begin
      if (in_sentence && wr_pos < MAX_SENTENCE_LEN) begin
        if (!marked || wr_pos < mark_pos + 2) begin
          body_mem[wr_pos] = ch;
          wr_pos++;
        end
        if (!marked) parity ^= ch;
      end
      if (in_sentence && marked && mark_pos > 0 && wr_pos == mark_pos + 2) begin
        in_sentence = 1'b0;
        sum         = checksum_of(body_mem[mark_pos], body_mem[mark_pos + 1]);
        match       = (parity == sum);
        for (int k = 0; k < mark_pos; k++) begin
          beat.data = body_mem[k];
          beat.len  = mark_pos[MSG_LEN_W-1:0];
          beat.ok   = match;
          beat.fin  = (k + 1 == mark_pos);
          body_beat_q.push_back(beat);
        end
        pending_o += mark_pos;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      body_beat_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
      parity       = '0;
      in_sentence  = 1'b0;
      wr_pos       = 0;
      marked       = 1'b0;
      mark_pos     = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (body_beat_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, msg_byte %02h", msg_byte_i));
        end else begin
          head = body_beat_q.pop_front();
          pending_o--;
          if (msg_byte_i !== head.data)
            report_mismatch($sformatf("msg_byte %02h, expected %02h", msg_byte_i, head.data));
          if (msg_length_i !== head.len)
            report_mismatch($sformatf("msg_length %0d, expected %0d", msg_length_i, head.len));
          if (checksum_ok_i !== head.ok)
            report_mismatch($sformatf("checksum_ok %b, expected %b", checksum_ok_i, head.ok));
          if (last_i !== head.fin)
            report_mismatch($sformatf("last %b, expected %b", last_i, head.fin));
        end
      end
      if (in_valid_i && in_ready_i) absorb_char(rx_byte_i);
    end
  end

endmodule

>>> test/tb.sv
// Testbench top for the NMEA sentence checksum parser: clock, reset, byte
// stimulus and result back-pressure. Depends on nscp_pkg, the parser unit
// and nscp_sentence_checker.
`timescale 1ns / 1ps

module tb;
  import nscp_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned END_SLACK    = 80;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned TARGET_CHARS = 430;
  localparam int unsigned DIRECTED_CNT = 26;

  typedef enum int unsigned {SUM_GOOD, SUM_WRONG, SUM_JUNK} sum_style_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [BYTE_W-1:0]    rx_byte;
  logic                 out_valid;
  logic                 out_ready;
  logic [BYTE_W-1:0]    msg_byte;
  logic [MSG_LEN_W-1:0] msg_length;
  logic                 checksum_ok;
  logic                 msg_last;

  int unsigned pending;
  int unsigned fail_count;
  int unsigned quiet_cycles = 0;
  int unsigned chars_sent = 0;
  int unsigned burst_left = 0;
  int unsigned ready_mode = 0;
  int unsigned stall_tick = 0;
  bit          gaps_on = 1'b0;
  bit          hold_req = 1'b0;

  always #6 clk = ~clk;

  nmea_sentence_checksum_parser_unit i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .msg_byte_o   (msg_byte),
    .msg_length_o (msg_length),
    .checksum_ok_o(checksum_ok),
    .last_o       (msg_last)
  );

  nscp_sentence_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .msg_byte_i   (msg_byte),
    .msg_length_i (msg_length),
    .checksum_ok_i(checksum_ok),
    .last_i       (msg_last),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  // Offer one byte and hold it until the transaction completes.
  task automatic send_char(input logic [7:0] ch);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    rx_byte  <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 10) return "0" + nib;
    return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_START || c == CH_MARK || c == CH_CR || c == CH_LF)
      c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] junk_digit();
    logic [7:0] c;
    c = body_char();
    while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"))
      c = body_char();
    return c;
  endfunction

  task automatic send_hex(input logic [7:0] v);
    send_char(hex_digit(v[7:4]));
    send_char(hex_digit(v[3:0]));
  endtask

  task automatic send_sentence(input int unsigned body_len, input sum_style_e style);
    logic [7:0] parity;
    logic [7:0] ch;
    parity = '0;
    send_char(CH_START);
    for (int i = 0; i < body_len; i++) begin
      ch = body_char();
      parity ^= ch;
      send_char(ch);
      // Line ends are dropped anywhere in the body.
      if ($urandom_range(0, 19) == 0) send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
    send_char(CH_MARK);
    case (style)
      SUM_GOOD:  send_hex(parity);
      SUM_WRONG: send_hex(parity ^ 8'($urandom_range(1, 255)));
      default: begin
        if ($urandom_range(0, 1)) begin
          send_char(junk_digit());
          send_char(hex_digit(parity[3:0]));
        end else begin
          send_char(hex_digit(parity[7:4]));
          send_char(junk_digit());
        end
      end
    endcase
  endtask

  task automatic send_random_unit();
    int unsigned pick;
    int unsigned r;
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 9);
    if (pick < 66) begin
      send_sentence($urandom_range(1, 12), r < 7 ? SUM_GOOD : (r < 9 ? SUM_WRONG : SUM_JUNK));
    end else if (pick < 72) begin
      send_sentence((r < 3) ? MAX_SENTENCE_LEN - 2 : $urandom_range(30, 61), SUM_GOOD);
    end else if (pick < 77) begin
      // Fill the buffer: the mark lands on the last slot or is dropped.
      send_char(CH_START);
      repeat ($urandom_range(MAX_SENTENCE_LEN - 1, MAX_SENTENCE_LEN + 4)) send_char(body_char());
      send_char(CH_MARK);
      send_hex(8'($urandom_range(0, 255)));
    end else if (pick < 84) begin
      // Empty body stalls; a second mark turns the checksum chars into a body.
      send_char(CH_START);
      send_char(CH_MARK);
      send_hex(8'($urandom_range(0, 255)));
      if (r < 6) begin
        send_char(CH_MARK);
        send_hex(r < 3 ? 8'h00 : 8'($urandom_range(0, 255)));
      end
    end else if (pick < 90) begin
      send_char(CH_START);
      repeat ($urandom_range(1, 6)) send_char(body_char());
      send_char(CH_MARK);
      if (r < 5) send_char(body_char());
      send_char(CH_MARK);
      send_hex(8'($urandom_range(0, 255)));
    end else if (pick < 95) begin
      send_char(CH_START);
      repeat ($urandom_range(0, 5)) send_char(body_char());
    end else begin
      repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Hold the input until every queued body byte has left.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall_tick++;
        case (ready_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= (stall_tick % 5 < 3);
          default: out_ready <= ($urandom_range(0, 9) < 4);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    rx_byte  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bytes outside a sentence are dropped.
    send_char(8'hFF);
    send_char(CH_MARK);
    // Extreme body bytes with line ends inside, mixed-case checksum.
    send_char(CH_START);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_CR);
    send_char(CH_LF);
    send_char(CH_MARK);
    send_text("Ff");
    // Empty body never completes.
    send_char(CH_START);
    send_char(CH_MARK);
    send_text("00");
    // Bad first digit reads as zero, matching an all-cancelling body.
    send_char(CH_START);
    send_text("AA");
    send_char(CH_MARK);
    send_text("Z5");
    // Second mark at the same spot, bad second digit.
    send_char(CH_START);
    send_text("J");
    send_char(CH_MARK);
    send_char(CH_MARK);
    send_text("4G");
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      ready_mode = phase;
      gaps_on    = (phase == 1 || phase == 3);
      if (phase == 2) hold_req = 1'b1;
      while (chars_sent < DIRECTED_CNT + (phase + 1) * (TARGET_CHARS - DIRECTED_CNT) / 4)
        send_random_unit();
      drain_results();
    end

    repeat (END_SLACK) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> nmea_sentence_checksum_parser_unit.f
hdl/nscp_pkg.sv
hdl/nscp_ram.sv
hdl/nscp_ctrl.sv
hdl/nscp_dpath.sv
hdl/nmea_sentence_checksum_parser_unit.sv
hdl/nscp_checker.sv
test/nscp_sentence_checker.sv
test/tb.sv
